// ----- src/rmq_pkg.sv -----
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int ONE = 1 << FRAC_BITS;

   // Widest radicand is a diagonal term minus two others plus one.
   localparam int RAD_W = $clog2(98304 + ONE + 1);
   localparam int RADS_W = RAD_W + 2;
   localparam int SQ_W = ((RAD_W + FRAC_BITS + 1) / 2) * 2;
   localparam int R_W = SQ_W / 2;
   localparam int S_W = 17;
   localparam int DIV_N_W = S_W + FRAC_BITS;
   localparam int D_W = R_W + 1;

   localparam logic [1:0] SEL_X = 2'd0;
   localparam logic [1:0] SEL_Y = 2'd1;
   localparam logic [1:0] SEL_Z = 2'd2;
   localparam logic [1:0] SEL_W = 2'd3;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic               degenerate;
   } rsp_item_type;

   // Classified item: radicand, three numerators and the component that takes r/2.
   typedef struct packed {
      logic [RAD_W-1:0]        rad;
      logic signed [S_W-1:0]   s0;
      logic signed [S_W-1:0]   s1;
      logic signed [S_W-1:0]   s2;
      logic [1:0]              sel;
      logic                    degen;
   } job_type;

   typedef struct packed {
      logic [1:0]       sel;
      logic             degen;
      logic [R_W-1:0]   r;
   } tag_type;

endpackage

// ----- src/rotation_matrix_to_quaternion.sv -----
// Converts a 3x3 rotation matrix of signed Q2.14 entries into the quaternion
// (x, y, z, w) in Q2.14, using the trace when it is not negative and the
// largest diagonal entry otherwise.
// Input channel: an item is taken at a rising clock edge with start high and
// busy low; req_item carries the nine matrix entries.
// Result channel: rsp_valid is high for exactly one cycle with rsp_item; the
// receiver must take it then, as there is no way to hold results off.
// Throughput is one item per clock cycle. From the accepting edge to the
// result cycle an item passes the queue register, a one-bit-per-stage square
// root of R_W stages, a one-bit-per-stage divider of DIV_N_W stages and an
// output register.
// The front classifies each item and writes it to a two-entry queue that the
// back pipeline drains every cycle, so busy stays low in normal operation.
// Synchronous reset empties the queue and drops all items in flight; no
// result appears in the cycle after reset.
module rotation_matrix_to_quaternion (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rmq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output rmq_pkg::rsp_item_type rsp_item
);

   rmq_pkg::job_type                        front_job;
   rmq_pkg::job_type                        head_job;
   logic                                    head_valid;
   logic                                    sq_valid;
   rmq_pkg::job_type                        sq_job;
   logic [rmq_pkg::R_W-1:0]                 sq_root;
   rmq_pkg::tag_type                        div_tag_in;
   logic [2:0][rmq_pkg::S_W-1:0]            div_num;
   logic                                    div_valid;
   rmq_pkg::tag_type                        div_tag;
   logic [2:0]                              div_neg;
   logic [2:0][rmq_pkg::DIV_N_W-1:0]        div_quo;
   logic                                    rsp_valid_ff;
   rmq_pkg::rsp_item_type                   rsp_item_ff, rsp_item_in;
   logic signed [15:0]                      lane [3];
   logic signed [15:0]                      half;
   logic [rmq_pkg::R_W-1:0]                 half_raw;

   // Saturate a signed quotient, given as sign and magnitude, to 16 bits.
   function automatic logic signed [15:0] sat_quo(input logic neg,
                                                  input logic [rmq_pkg::DIV_N_W-1:0] mag);
      logic signed [15:0] res;
      if (neg) begin
         res = (mag > rmq_pkg::DIV_N_W'(32768)) ? 16'sh8000 : 16'(-mag);
      end else begin
         res = (mag > rmq_pkg::DIV_N_W'(32767)) ? 16'sh7fff : 16'(mag);
      end
      return res;
   endfunction

   // Front: classify the matrix into radicand, numerators and the chosen component.
   rmq_front u_front (
      .req_item (req_item),
      .job      (front_job)
   );

   rmq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (start),
      .push_job   (front_job),
      .full       (busy),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Back: square root, then the three divisions by 2r side by side.
   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (head_valid),
      .in_job    (head_job),
      .out_valid (sq_valid),
      .out_job   (sq_job),
      .out_root  (sq_root)
   );

   always_comb begin
      div_tag_in.sel = sq_job.sel;
      div_tag_in.degen = sq_job.degen;
      div_tag_in.r = sq_root;
      div_num[0] = sq_job.s0;
      div_num[1] = sq_job.s1;
      div_num[2] = sq_job.s2;
   end

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_tag    (div_tag_in),
      .in_num    (div_num),
      .out_valid (div_valid),
      .out_tag   (div_tag),
      .out_neg   (div_neg),
      .out_quo   (div_quo)
   );

   // Route the three quotients and r/2 to the components named by the selection.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         lane[l] = sat_quo(div_neg[l], div_quo[l]);
      end
      half_raw = div_tag.r >> 1;
      if ((rmq_pkg::R_W + 16)'(half_raw) > (rmq_pkg::R_W + 16)'(32767)) begin
         half = 16'sh7fff;
      end else begin
         half = 16'(half_raw);
      end

      rsp_item_in = '0;
      case (div_tag.sel)
         rmq_pkg::SEL_X: begin
            rsp_item_in.quat_x = half;
            rsp_item_in.quat_y = lane[0];
            rsp_item_in.quat_z = lane[1];
            rsp_item_in.quat_w = lane[2];
         end
         rmq_pkg::SEL_Y: begin
            rsp_item_in.quat_y = half;
            rsp_item_in.quat_z = lane[0];
            rsp_item_in.quat_x = lane[1];
            rsp_item_in.quat_w = lane[2];
         end
         rmq_pkg::SEL_Z: begin
            rsp_item_in.quat_z = half;
            rsp_item_in.quat_x = lane[0];
            rsp_item_in.quat_y = lane[1];
            rsp_item_in.quat_w = lane[2];
         end
         default: begin
            rsp_item_in.quat_x = lane[0];
            rsp_item_in.quat_y = lane[1];
            rsp_item_in.quat_z = lane[2];
            rsp_item_in.quat_w = half;
         end
      endcase

      // A degenerate item reports the zero quaternion.
      if (div_tag.degen) begin
         rsp_item_in = '0;
         rsp_item_in.degenerate = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

`ifndef SYNTH
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe high right after reset");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.degenerate |->
         rsp_item.quat_x == 16'sd0 && rsp_item.quat_y == 16'sd0 &&
         rsp_item.quat_z == 16'sd0 && rsp_item.quat_w == 16'sd0)
      else $error("degenerate item with a nonzero quaternion");

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("queue filled although the back part drains every cycle");
`endif

endmodule

// ----- src/rmq_front.sv -----
module rmq_front (
   input  rmq_pkg::req_item_type req_item,
   output rmq_pkg::job_type      job
);

   localparam logic signed [rmq_pkg::RADS_W-1:0] ONE_S = rmq_pkg::RADS_W'(rmq_pkg::ONE);

   logic signed [17:0]                 tr;
   logic [1:0]                         pick;
   logic signed [rmq_pkg::RADS_W-1:0]  rad;
   logic                               nonneg;

   always_comb begin
      tr = 18'(req_item.m00) + 18'(req_item.m11) + 18'(req_item.m22);
      nonneg = !tr[17];

      // Ties keep the lower diagonal index.
      pick = 2'd0;
      if (req_item.m11 > req_item.m00) begin
         pick = 2'd1;
      end
      if (req_item.m22 > ((pick == 2'd1) ? req_item.m11 : req_item.m00)) begin
         pick = 2'd2;
      end

      job = '0;
      if (nonneg) begin
         rad = rmq_pkg::RADS_W'(tr) + ONE_S;
         job.s0 = rmq_pkg::S_W'(req_item.m21) - rmq_pkg::S_W'(req_item.m12);
         job.s1 = rmq_pkg::S_W'(req_item.m02) - rmq_pkg::S_W'(req_item.m20);
         job.s2 = rmq_pkg::S_W'(req_item.m10) - rmq_pkg::S_W'(req_item.m01);
         job.sel = rmq_pkg::SEL_W;
      end else begin
         case (pick)
            2'd1: begin
               rad = rmq_pkg::RADS_W'(req_item.m11) - rmq_pkg::RADS_W'(req_item.m22)
                     - rmq_pkg::RADS_W'(req_item.m00) + ONE_S;
               job.s0 = rmq_pkg::S_W'(req_item.m12) + rmq_pkg::S_W'(req_item.m21);
               job.s1 = rmq_pkg::S_W'(req_item.m01) + rmq_pkg::S_W'(req_item.m10);
               job.s2 = rmq_pkg::S_W'(req_item.m02) - rmq_pkg::S_W'(req_item.m20);
               job.sel = rmq_pkg::SEL_Y;
            end
            2'd2: begin
               rad = rmq_pkg::RADS_W'(req_item.m22) - rmq_pkg::RADS_W'(req_item.m00)
                     - rmq_pkg::RADS_W'(req_item.m11) + ONE_S;
               job.s0 = rmq_pkg::S_W'(req_item.m20) + rmq_pkg::S_W'(req_item.m02);
               job.s1 = rmq_pkg::S_W'(req_item.m12) + rmq_pkg::S_W'(req_item.m21);
               job.s2 = rmq_pkg::S_W'(req_item.m10) - rmq_pkg::S_W'(req_item.m01);
               job.sel = rmq_pkg::SEL_Z;
            end
            default: begin
               rad = rmq_pkg::RADS_W'(req_item.m00) - rmq_pkg::RADS_W'(req_item.m11)
                     - rmq_pkg::RADS_W'(req_item.m22) + ONE_S;
               job.s0 = rmq_pkg::S_W'(req_item.m01) + rmq_pkg::S_W'(req_item.m10);
               job.s1 = rmq_pkg::S_W'(req_item.m20) + rmq_pkg::S_W'(req_item.m02);
               job.s2 = rmq_pkg::S_W'(req_item.m21) - rmq_pkg::S_W'(req_item.m12);
               job.sel = rmq_pkg::SEL_X;
            end
         endcase
      end

      // A radicand of zero or less yields the zero quaternion.
      job.degen = !nonneg && (rad <= 0);
      job.rad = job.degen ? '0 : rad[rmq_pkg::RAD_W-1:0];
   end

endmodule

// ----- src/rmq_queue.sv -----
module rmq_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rmq_pkg::job_type push_job,
   output logic             full,
   output logic             head_valid,
   output rmq_pkg::job_type head_job
);

   rmq_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   // The back part takes the head item in every cycle that one is present.
   assign full = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- src/rmq_sqrt.sv -----
module rmq_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  rmq_pkg::job_type           in_job,
   output logic                       out_valid,
   output rmq_pkg::job_type           out_job,
   output logic [rmq_pkg::R_W-1:0]    out_root
);

   localparam int N = rmq_pkg::R_W;
   localparam int REM_W = rmq_pkg::R_W + 3;

   logic                       val_s  [0:N];
   rmq_pkg::job_type           job_s  [0:N];
   logic [rmq_pkg::SQ_W-1:0]   v_s    [0:N];
   logic [REM_W-1:0]           rem_s  [0:N];
   logic [N-1:0]               q_s    [0:N];

   assign val_s[0] = in_valid;
   assign job_s[0] = in_job;
   assign v_s[0] = rmq_pkg::SQ_W'({in_job.rad, {rmq_pkg::FRAC_BITS{1'b0}}});
   assign rem_s[0] = '0;
   assign q_s[0] = '0;

   // One root bit per stage, most significant first.
   for (genvar s = 0; s < N; s++) begin : g_stage
      localparam int K = N - 1 - s;
      logic                       val_ff;
      rmq_pkg::job_type           job_ff;
      logic [rmq_pkg::SQ_W-1:0]   v_ff;
      logic [REM_W-1:0]           rem_ff, rem_in;
      logic [N-1:0]               q_ff, q_in;
      logic [REM_W-1:0]           rem_sh;
      logic [REM_W-1:0]           trial;

      always_comb begin
         rem_sh = {rem_s[s][REM_W-3:0], v_s[s][2*K+1 -: 2]};
         trial = REM_W'({q_s[s], 2'b01});
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            q_in = {q_s[s][N-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in = {q_s[s][N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff <= 1'b0;
         end else begin
            val_ff <= val_s[s];
         end
      end

      always_ff @(posedge clock) begin
         job_ff <= job_s[s];
         v_ff <= v_s[s];
         rem_ff <= rem_in;
         q_ff <= q_in;
      end

      assign val_s[s+1] = val_ff;
      assign job_s[s+1] = job_ff;
      assign v_s[s+1] = v_ff;
      assign rem_s[s+1] = rem_ff;
      assign q_s[s+1] = q_ff;
   end

   assign out_valid = val_s[N];
   assign out_job = job_s[N];
   assign out_root = q_s[N];

endmodule

// ----- src/rmq_div.sv -----
module rmq_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  rmq_pkg::tag_type                    in_tag,
   input  logic [2:0][rmq_pkg::S_W-1:0]        in_num,
   output logic                                out_valid,
   output rmq_pkg::tag_type                    out_tag,
   output logic [2:0]                          out_neg,
   output logic [2:0][rmq_pkg::DIV_N_W-1:0]    out_quo
);

   localparam int N = rmq_pkg::DIV_N_W;
   localparam int DW = rmq_pkg::D_W;

   logic                   val_s [0:N];
   rmq_pkg::tag_type       tag_s [0:N];
   logic [DW-1:0]          dv_s  [0:N];
   logic [2:0]             neg_s [0:N];
   logic [2:0][N-1:0]      dn_s  [0:N];
   logic [2:0][DW-1:0]     rem_s [0:N];
   logic [2:0][N-1:0]      qt_s  [0:N];
   logic [rmq_pkg::S_W-1:0] mag [3];
   logic [2:0]             neg0;
   logic [2:0][N-1:0]      dn0;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag[l] = in_num[l][rmq_pkg::S_W-1] ? -in_num[l] : in_num[l];
         neg0[l] = in_num[l][rmq_pkg::S_W-1];
         dn0[l] = {mag[l], {rmq_pkg::FRAC_BITS{1'b0}}};
      end
   end

   assign val_s[0] = in_valid;
   assign tag_s[0] = in_tag;
   assign dv_s[0] = {in_tag.r, 1'b0};
   assign neg_s[0] = neg0;
   assign dn_s[0] = dn0;
   assign rem_s[0] = '0;
   assign qt_s[0] = '0;

   // Restoring division, one quotient bit per stage in each of three lanes.
   for (genvar s = 0; s < N; s++) begin : g_stage
      logic                 val_ff;
      rmq_pkg::tag_type     tag_ff;
      logic [DW-1:0]        dv_ff;
      logic [2:0]           neg_ff;
      logic [2:0][N-1:0]    dn_ff;
      logic [2:0][DW-1:0]   rem_ff, rem_in;
      logic [2:0][N-1:0]    qt_ff, qt_in;
      logic [DW:0]          rsh [3];

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            rsh[l] = {rem_s[s][l], dn_s[s][l][N-1-s]};
            if (rsh[l] >= {1'b0, dv_s[s]}) begin
               rem_in[l] = DW'(rsh[l] - {1'b0, dv_s[s]});
               qt_in[l] = {qt_s[s][l][N-2:0], 1'b1};
            end else begin
               rem_in[l] = rsh[l][DW-1:0];
               qt_in[l] = {qt_s[s][l][N-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff <= 1'b0;
         end else begin
            val_ff <= val_s[s];
         end
      end

      always_ff @(posedge clock) begin
         tag_ff <= tag_s[s];
         dv_ff <= dv_s[s];
         neg_ff <= neg_s[s];
         dn_ff <= dn_s[s];
         rem_ff <= rem_in;
         qt_ff <= qt_in;
      end

      assign val_s[s+1] = val_ff;
      assign tag_s[s+1] = tag_ff;
      assign dv_s[s+1] = dv_ff;
      assign neg_s[s+1] = neg_ff;
      assign dn_s[s+1] = dn_ff;
      assign rem_s[s+1] = rem_ff;
      assign qt_s[s+1] = qt_ff;
   end

   assign out_valid = val_s[N];
   assign out_tag = tag_s[N];
   assign out_neg = neg_s[N];
   assign out_quo = qt_s[N];

endmodule

// ----- sim/rmq_checker.sv -----
module rmq_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  rmq_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  rmq_pkg::rsp_item_type rsp_item,
   output int                    fail_count,
   output int                    pending_count,
   output int                    degenerate_seen,
   output int                    negative_trace_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   rmq_pkg::rsp_item_type quat_queue[$];
   int                    mismatch_count;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint ratio(longint s, longint unsigned r);
      longint unsigned mag;
      longint unsigned q;
      mag = (s < 0 ? -s : s) << rmq_pkg::FRAC_BITS;
      q = mag / (2 * r);
      return s < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic rmq_pkg::rsp_item_type predict_quat(rmq_pkg::req_item_type it);
      longint                m[3][3];
      longint                q[3];
      longint                w;
      longint                tr;
      longint                rad;
      longint unsigned       r;
      int                    a, b, c;
      rmq_pkg::rsp_item_type res;
      m[0][0] = it.m00; m[0][1] = it.m01; m[0][2] = it.m02;
      m[1][0] = it.m10; m[1][1] = it.m11; m[1][2] = it.m12;
      m[2][0] = it.m20; m[2][1] = it.m21; m[2][2] = it.m22;
      q[0] = 0; q[1] = 0; q[2] = 0; w = 0;
      res.degenerate = 1'b0;
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr >= 0) begin
         rad = tr + rmq_pkg::ONE;
         r = int_sqrt(longint'(rad) << rmq_pkg::FRAC_BITS);
         q[0] = ratio(m[2][1] - m[1][2], r);
         q[1] = ratio(m[0][2] - m[2][0], r);
         q[2] = ratio(m[1][0] - m[0][1], r);
         w = longint'(r >> 1);
      end else begin
         a = 0;
         if (m[1][1] > m[a][a]) a = 1;
         if (m[2][2] > m[a][a]) a = 2;
         b = (a + 1) % 3;
         c = (a + 2) % 3;
         rad = m[a][a] - m[b][b] - m[c][c] + rmq_pkg::ONE;
         if (rad <= 0) begin
            res.degenerate = 1'b1;
         end else begin
            r = int_sqrt(longint'(rad) << rmq_pkg::FRAC_BITS);
            q[a] = longint'(r >> 1);
            q[b] = ratio(m[a][b] + m[b][a], r);
            q[c] = ratio(m[c][a] + m[a][c], r);
            w = ratio(m[c][b] - m[b][c], r);
         end
      end
      res.quat_x = 16'(clamp16(q[0]));
      res.quat_y = 16'(clamp16(q[1]));
      res.quat_z = 16'(clamp16(q[2]));
      res.quat_w = 16'(clamp16(w));
      return res;
   endfunction

   always @(posedge clock) begin
      rmq_pkg::rsp_item_type want;
      if (reset) begin
         quat_queue.delete();
      end else begin
         if (start && !busy) begin
            want = predict_quat(req_item);
            quat_queue.push_back(want);
            if (want.degenerate) degenerate_seen <= degenerate_seen + 1;
            if (req_item.m00 + req_item.m11 + req_item.m22 < 0)
               negative_trace_seen <= negative_trace_seen + 1;
         end
         if (rsp_valid) begin
            if (quat_queue.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("unexpected quaternion %h", rsp_item);
            end else begin
               want = quat_queue.pop_front();
               if (rsp_item !== want) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("quaternion mismatch: x %0d/%0d y %0d/%0d z %0d/%0d w %0d/%0d deg %b/%b",
                              want.quat_x, rsp_item.quat_x, want.quat_y, rsp_item.quat_y,
                              want.quat_z, rsp_item.quat_z, want.quat_w, rsp_item.quat_w,
                              want.degenerate, rsp_item.degenerate);
               end
            end
         end
      end
      fail_count <= mismatch_count;
      pending_count <= quat_queue.size();
   end

   initial begin
      mismatch_count = 0;
      fail_count = 0;
      pending_count = 0;
      degenerate_seen = 0;
      negative_trace_seen = 0;
   end
endmodule

// ----- sim/tb_rotation_matrix_to_quaternion.sv -----
module tb_rotation_matrix_to_quaternion;
   timeunit 1ns;
   timeprecision 1ps;

   // The drain wait covers the block's pipeline with margin.
   localparam int DRAIN_CYCLES = 80;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   rmq_pkg::req_item_type req_item = '0;
   logic                  rsp_valid;
   rmq_pkg::rsp_item_type rsp_item;
   int                    fail_count;
   int                    pending_count;
   int                    degenerate_seen;
   int                    negative_trace_seen;
   int                    items_sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rotation_matrix_to_quaternion dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   rmq_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .fail_count(fail_count), .pending_count(pending_count),
      .degenerate_seen(degenerate_seen), .negative_trace_seen(negative_trace_seen)
   );

   // A random entry: mostly within [-1, 1] as a real rotation would give, but
   // every so often an arbitrary 16-bit pattern so that all bits toggle and
   // the saturating paths are reached.
   function automatic logic signed [15:0] rand_entry();
      case ($urandom_range(0, 7))
         0: return 16'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
         default: return 16'($signed($urandom_range(0, 2 * rmq_pkg::ONE)) - rmq_pkg::ONE);
      endcase
   endfunction

   // Builds a matrix that may steer toward one of the branches: each choice of
   // largest diagonal entry and ties on the diagonal; else the entries stay random.
   function automatic rmq_pkg::req_item_type rand_matrix();
      rmq_pkg::req_item_type it;
      int                    pick;
      logic signed [15:0]    big;
      logic signed [15:0]    neg_one;
      logic signed [15:0]    neg_half;
      neg_one = 16'(-rmq_pkg::ONE);
      neg_half = 16'(-rmq_pkg::ONE / 2);
      it.m00 = rand_entry(); it.m01 = rand_entry(); it.m02 = rand_entry();
      it.m10 = rand_entry(); it.m11 = rand_entry(); it.m12 = rand_entry();
      it.m20 = rand_entry(); it.m21 = rand_entry(); it.m22 = rand_entry();
      pick = $urandom_range(0, 9);
      big = 16'($signed($urandom_range(0, rmq_pkg::ONE)) - rmq_pkg::ONE);
      case (pick)
         0: begin it.m00 = big; it.m11 = neg_one; it.m22 = neg_one; end
         1: begin it.m11 = big; it.m00 = neg_one; it.m22 = neg_one; end
         2: begin it.m22 = big; it.m00 = neg_one; it.m11 = neg_one; end
         3: begin it.m00 = big; it.m11 = big; it.m22 = neg_one; end
         4: begin it.m00 = neg_half; it.m11 = neg_half; it.m22 = neg_half; end
         default: ;
      endcase
      return it;
   endfunction

   task automatic send_item(rmq_pkg::req_item_type it);
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent = items_sent + 1;
   endtask

   task automatic pause_sender();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_diag(int d0, int d1, int d2, int off);
      rmq_pkg::req_item_type it;
      it = '{m00: 16'(d0), m01: 16'(off), m02: 16'(-off), m10: 16'(-off), m11: 16'(d1),
             m12: 16'(off), m20: 16'(off), m21: 16'(-off), m22: 16'(d2)};
      send_item(it);
   endtask

   initial begin
      int burst;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: identity, half turns about each axis, ties on the
      // diagonal, and the field extremes.
      send_diag(rmq_pkg::ONE, rmq_pkg::ONE, rmq_pkg::ONE, 0);
      send_diag(rmq_pkg::ONE, -rmq_pkg::ONE, -rmq_pkg::ONE, 0);
      send_diag(-rmq_pkg::ONE, rmq_pkg::ONE, -rmq_pkg::ONE, 0);
      send_diag(-rmq_pkg::ONE, -rmq_pkg::ONE, rmq_pkg::ONE, 0);
      send_diag(-rmq_pkg::ONE / 2, -rmq_pkg::ONE / 2, -rmq_pkg::ONE / 2, 100);
      send_diag(-rmq_pkg::ONE / 3, -rmq_pkg::ONE / 3, -rmq_pkg::ONE / 2, 50);
      send_diag(-rmq_pkg::ONE, -rmq_pkg::ONE / 2, -rmq_pkg::ONE / 2, 0);
      send_diag(-32768, -32768, -32768, 32767);
      send_diag(32767, 32767, 32767, -32768);
      send_diag(32767, -32768, -32768, 32767);
      send_diag(-32768, 32767, -32768, -32768);
      send_diag(-32768, -32768, 32767, 32767);
      send_diag(0, 0, 0, 32767);
      send_diag(0, 0, -1, -32768);
      send_diag(-1, -1, -1, 1);
      send_item('1);
      send_item('0);
      send_item('{default: 16'sh5555});
      send_item('{default: 16'shaaaa});
      pause_sender();

      // Random part: bursts of items separated by random gaps, with one
      // stretch where the sender waits for every result before going on.
      while (items_sent < 430) begin
         burst = $urandom_range(1, 30);
         repeat (burst) send_item(rand_matrix());
         if (items_sent > 200 && items_sent < 240) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end else if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clock);
         end
      end
      start <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d matrices, %0d with negative trace, %0d degenerate.",
               items_sent, negative_trace_seen, degenerate_seen);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #200000;
      $display("Timeout");
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
